// ----- hdl/dtc_pkg.sv -----
// Package for the digit template classifier: shared constants, operation codes
// and the control word that the sequencer sends to every class cell.
// No dependencies.
`default_nettype none

package dtc_pkg;

  // Default sizes of the classifier.
  localparam int NUM_CLASSES_DEF = 10;
  localparam int NUM_PIXELS_DEF  = 25;
  localparam int CONF_WIDTH_DEF  = 16;

  // Fixed field widths of the item and result words.
  localparam int IMAGE_W = 25;
  localparam int LABEL_W = 4;
  localparam int CLASS_W = 4;
  localparam int SCORE_W = 22;

  // Number of pixel terms that a cell adds into its score in one cycle.
  localparam int PIX_PER_STEP = 8;

  // Operation codes of the operation field.
  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_TRAIN    = 1'b1;

  // Control word broadcast from the sequencer to all class cells.
  typedef struct packed {
    logic clear;  // zero the score accumulator
    logic accum;  // add the selected pixel group into the accumulator
    logic train;  // apply one training update
    logic fair;   // raise the counters of the classes that are not labelled
  } ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/dtc_cell.sv -----
// One class cell of the classifier chain: template, confidence counters, score
// accumulator and one compare stage of the best-class chain.
// Depends on dtc_pkg.
`default_nettype none

module dtc_cell
  import dtc_pkg::*;
#(
  parameter int NUM_PIXELS = NUM_PIXELS_DEF,
  parameter int CONF_WIDTH = CONF_WIDTH_DEF,
  parameter int CLASS_IDX  = 0,
  parameter int ACC_W      = CONF_WIDTH + $clog2(NUM_PIXELS + 1) + 1,
  parameter int GW         = 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ctrl_t                   ctrl_i,
  input  wire logic [NUM_PIXELS-1:0]   pix_i,
  input  wire logic [LABEL_W-1:0]      label_i,
  input  wire logic [GW-1:0]           grp_i,
  input  wire logic [CLASS_W-1:0]      prev_class_i,
  input  wire logic signed [ACC_W-1:0] prev_score_i,
  output logic      [CLASS_W-1:0]      best_class_o,
  output logic signed [ACC_W-1:0]      best_score_o
);

  localparam int NG_PAD = 1 << GW;
  localparam logic [CONF_WIDTH-1:0] CONF_MAX = {CONF_WIDTH{1'b1}};
  localparam logic [CLASS_W-1:0]    MY_CLASS = CLASS_W'(CLASS_IDX);

  logic [NUM_PIXELS-1:0] tmpl_q, tmpl_d;
  logic [CONF_WIDTH-1:0] conf_q [NUM_PIXELS];
  logic [CONF_WIDTH-1:0] conf_d [NUM_PIXELS];
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] grp_sum;
  logic [CLASS_W-1:0]      best_class_q, best_class_d;
  logic signed [ACC_W-1:0] best_score_q, best_score_d;
  logic                    mine;

  // Pixel groups padded to a power of two; pixels past the end score zero.
  logic [CONF_WIDTH-1:0]   conf_pad  [NG_PAD][PIX_PER_STEP];
  logic [PIX_PER_STEP-1:0] match_pad [NG_PAD];

  for (genvar g = 0; g < NG_PAD; g++) begin : g_grp
    for (genvar j = 0; j < PIX_PER_STEP; j++) begin : g_pix
      localparam int P = g * PIX_PER_STEP + j;
      if (P < NUM_PIXELS) begin : g_real
        assign conf_pad[g][j]  = conf_q[P];
        assign match_pad[g][j] = (pix_i[P] == tmpl_q[P]);
      end else begin : g_pad
        assign conf_pad[g][j]  = '0;
        assign match_pad[g][j] = 1'b1;
      end
    end
  end

  // Signed sum of the selected pixel group.
  always_comb begin
    logic signed [ACC_W-1:0] term;
    grp_sum = '0;
    for (int j = 0; j < PIX_PER_STEP; j++) begin
      term = $signed({{(ACC_W-CONF_WIDTH){1'b0}}, conf_pad[grp_i][j]});
      if (match_pad[grp_i][j]) begin
        grp_sum = grp_sum + term;
      end else begin
        grp_sum = grp_sum - term;
      end
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.accum) begin
      acc_d = acc_q + grp_sum;
    end
  end

  // Training update, all counters of the cell in parallel.
  assign mine = (label_i == MY_CLASS);

  always_comb begin
    logic hit;
    logic raise;
    tmpl_d = tmpl_q;
    for (int p = 0; p < NUM_PIXELS; p++) begin
      hit       = (pix_i[p] == tmpl_q[p]);
      raise     = (ctrl_i.fair && !mine) || (mine && hit);
      conf_d[p] = conf_q[p];
      if (ctrl_i.train) begin
        if (raise) begin
          if (conf_q[p] != CONF_MAX) begin
            conf_d[p] = conf_q[p] + 1'b1;
          end
        end else if (mine) begin
          if (conf_q[p] == '0) begin
            tmpl_d[p] = ~tmpl_q[p];
            conf_d[p] = CONF_WIDTH'(1);
          end else begin
            conf_d[p] = conf_q[p] - 1'b1;
          end
        end
      end
    end
  end

  // Chain stage: keep the neighbor's best unless this class scores strictly higher.
  always_comb begin
    if (CLASS_IDX == 0 || acc_q > prev_score_i) begin
      best_class_d = MY_CLASS;
      best_score_d = acc_q;
    end else begin
      best_class_d = prev_class_i;
      best_score_d = prev_score_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmpl_q       <= '0;
      acc_q        <= '0;
      best_class_q <= '0;
      best_score_q <= '0;
      for (int p = 0; p < NUM_PIXELS; p++) begin
        conf_q[p] <= '0;
      end
    end else begin
      tmpl_q       <= tmpl_d;
      acc_q        <= acc_d;
      best_class_q <= best_class_d;
      best_score_q <= best_score_d;
      for (int p = 0; p < NUM_PIXELS; p++) begin
        conf_q[p] <= conf_d[p];
      end
    end
  end

  assign best_class_o = best_class_q;
  assign best_score_o = best_score_q;

endmodule

`default_nettype wire

// ----- hdl/dtc_ctrl.sv -----
// Sequencer of the classifier: input capture, phase control of the cell chain
// and the result word register.
// Depends on dtc_pkg.
`default_nettype none

module dtc_ctrl
  import dtc_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int NUM_GROUPS  = 4,
  parameter int ACC_W       = 22,
  parameter int GW          = 2
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    operation_i,
  input  wire logic [IMAGE_W-1:0]      image_i,
  input  wire logic [LABEL_W-1:0]      label_i,
  input  wire logic                    fair_mode_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [CLASS_W-1:0]           predicted_class_o,
  output logic signed [SCORE_W-1:0]    best_score_o,
  output logic                         label_invalid_o,
  output ctrl_t                        ctrl_o,
  output logic [IMAGE_W-1:0]           image_o,
  output logic [LABEL_W-1:0]           label_o,
  output logic [GW-1:0]                grp_o,
  input  wire logic [CLASS_W-1:0]      chain_class_i,
  input  wire logic signed [ACC_W-1:0] chain_score_i
);

  localparam int MAXC  = (NUM_CLASSES > NUM_GROUPS) ? NUM_CLASSES : NUM_GROUPS;
  localparam int CNT_W = $clog2(MAXC + 1);
  localparam logic [CNT_W-1:0]   LAST_GRP   = CNT_W'(NUM_GROUPS - 1);
  localparam logic [CNT_W-1:0]   LAST_CLASS = CNT_W'(NUM_CLASSES - 1);
  localparam logic [CLASS_W:0]   CLASS_LIM  = (CLASS_W+1)'(NUM_CLASSES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCUM,
    S_CHAIN,
    S_TRAIN,
    S_RESULT
  } state_e;

  state_e               state_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 op_q;
  logic [IMAGE_W-1:0]   image_q;
  logic [LABEL_W-1:0]   label_q;
  logic                 fair_q;
  logic                 inv_q;
  logic                 out_valid_q;
  logic [CLASS_W-1:0]   class_q;
  logic signed [SCORE_W-1:0] score_q;
  logic                 invalid_q;
  logic                 accept;
  logic                 load;
  logic                 bad_label;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load       = (state_q == S_RESULT) && (!out_valid_q || out_ready_i);
  assign bad_label  = ({1'b0, label_i} >= CLASS_LIM);

  // Sequencer and result word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      op_q        <= OP_CLASSIFY;
      image_q     <= '0;
      label_q     <= '0;
      fair_q      <= 1'b0;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      class_q     <= '0;
      score_q     <= '0;
      invalid_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q    <= operation_i;
            image_q <= image_i;
            label_q <= label_i;
            fair_q  <= fair_mode_i;
            inv_q   <= (operation_i == OP_TRAIN) && bad_label;
            cnt_q   <= '0;
            if (operation_i == OP_CLASSIFY) begin
              state_q <= S_ACCUM;
            end else if (bad_label) begin
              state_q <= S_RESULT;
            end else begin
              state_q <= S_TRAIN;
            end
          end
        end
        S_ACCUM: begin
          if (cnt_q == LAST_GRP) begin
            cnt_q   <= '0;
            state_q <= S_CHAIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_CHAIN: begin
          if (cnt_q == LAST_CLASS) begin
            cnt_q   <= '0;
            state_q <= S_RESULT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_TRAIN: begin
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (load) begin
            out_valid_q <= 1'b1;
            if (op_q == OP_CLASSIFY) begin
              class_q   <= chain_class_i;
              score_q   <= SCORE_W'(chain_score_i);
              invalid_q <= 1'b0;
            end else begin
              class_q   <= '0;
              score_q   <= '0;
              invalid_q <= inv_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Control word for the cells.
  always_comb begin
    ctrl_o.clear = (state_q == S_IDLE);
    ctrl_o.accum = (state_q == S_ACCUM);
    ctrl_o.train = (state_q == S_TRAIN);
    ctrl_o.fair  = fair_q;
  end

  assign image_o           = image_q;
  assign label_o           = label_q;
  assign grp_o             = cnt_q[GW-1:0];
  assign out_valid_o       = out_valid_q;
  assign predicted_class_o = class_q;
  assign best_score_o      = score_q;
  assign label_invalid_o   = invalid_q;

`ifndef SYNTH
  // Training only ever runs for a label that names an existing class.
  a_train_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.train |-> ({1'b0, label_q} < CLASS_LIM))
    else $error("training update with an out-of-range label");

  // A new word only appears after the result phase.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_RESULT))
    else $error("result word raised outside the result phase");

  // One item at a time: after an accept the input side stays closed.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again while an item is in work");

  // A predicted class always names an existing class.
  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, predicted_class_o} < CLASS_LIM))
    else $error("predicted class out of range");

  // A rejected train word carries no class and no score.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && label_invalid_o) |-> (predicted_class_o == '0 && best_score_o == '0))
    else $error("rejected train word with nonzero class or score");
`endif

endmodule

`default_nettype wire

// ----- hdl/digit_template_classifier_top.sv -----
// Top level of the digit template classifier: sequencer plus a chain of class
// cells. Depends on dtc_pkg, dtc_ctrl and dtc_cell.
`default_nettype none

// The block takes one word at a time. For a classify word, each class cell adds
// eight pixel terms into its score per cycle, and the best class then moves down
// the cell chain one class per cycle. A train word passes through the training
// state; a rejected train word goes straight to the result phase. The result
// word sits in an output register, so the next word is taken while a finished
// result still waits. All templates and counters are zero after reset.
module digit_template_classifier_top
  import dtc_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int NUM_PIXELS  = NUM_PIXELS_DEF,
  parameter int CONF_WIDTH  = CONF_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 operation_i,
  input  wire logic [IMAGE_W-1:0]   image_i,
  input  wire logic [LABEL_W-1:0]   label_i,
  input  wire logic                 fair_mode_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [CLASS_W-1:0]        predicted_class_o,
  output logic signed [SCORE_W-1:0] best_score_o,
  output logic                      label_invalid_o
);

  localparam int ACC_W      = CONF_WIDTH + $clog2(NUM_PIXELS + 1) + 1;
  localparam int NUM_GROUPS = (NUM_PIXELS + PIX_PER_STEP - 1) / PIX_PER_STEP;
  localparam int GW         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  ctrl_t                   ctrl;
  logic [IMAGE_W-1:0]      image_q;
  logic [LABEL_W-1:0]      label_q;
  logic [GW-1:0]           grp;
  logic [NUM_PIXELS-1:0]   pix;
  logic [CLASS_W-1:0]      chain_class [NUM_CLASSES+1];
  logic signed [ACC_W-1:0] chain_score [NUM_CLASSES+1];

  dtc_ctrl #(
    .NUM_CLASSES (NUM_CLASSES),
    .NUM_GROUPS  (NUM_GROUPS),
    .ACC_W       (ACC_W),
    .GW          (GW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .image_i           (image_i),
    .label_i           (label_i),
    .fair_mode_i       (fair_mode_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .predicted_class_o (predicted_class_o),
    .best_score_o      (best_score_o),
    .label_invalid_o   (label_invalid_o),
    .ctrl_o            (ctrl),
    .image_o           (image_q),
    .label_o           (label_q),
    .grp_o             (grp),
    .chain_class_i     (chain_class[NUM_CLASSES]),
    .chain_score_i     (chain_score[NUM_CLASSES])
  );

  // Pixels beyond the image field read as zero.
  for (genvar p = 0; p < NUM_PIXELS; p++) begin : g_pix
    if (p < IMAGE_W) begin : g_in
      assign pix[p] = image_q[p];
    end else begin : g_zero
      assign pix[p] = 1'b0;
    end
  end

  // The head of the chain has no neighbor.
  assign chain_class[0] = '0;
  assign chain_score[0] = '0;

  // One cell per class, each passing its best-so-far to the next.
  for (genvar n = 0; n < NUM_CLASSES; n++) begin : g_cell
    dtc_cell #(
      .NUM_PIXELS (NUM_PIXELS),
      .CONF_WIDTH (CONF_WIDTH),
      .CLASS_IDX  (n),
      .ACC_W      (ACC_W),
      .GW         (GW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .pix_i        (pix),
      .label_i      (label_q),
      .grp_i        (grp),
      .prev_class_i (chain_class[n]),
      .prev_score_i (chain_score[n]),
      .best_class_o (chain_class[n+1]),
      .best_score_o (chain_score[n+1])
    );
  end

endmodule

`default_nettype wire

// ----- tb/sv/digit_template_classifier_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for digit_template_classifier_top: drives classify and
// train words and checks every result word against a predicted template state.
// Depends on dtc_pkg and the classifier RTL.
module digit_template_classifier_top_tb
  import dtc_pkg::*;
();

  localparam int NCLS          = NUM_CLASSES_DEF;
  localparam int NPIX          = NUM_PIXELS_DEF;
  localparam int CONFW         = CONF_WIDTH_DEF;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int SAT_WORDS     = 32;

  // One expected result word.
  typedef struct {
    logic [CLASS_W-1:0]        cls;
    logic signed [SCORE_W-1:0] score;
    logic                      invalid;
  } verdict_t;

  // Keeps its own copy of the templates and counters and the queue of verdicts
  // that the block still owes.
  class template_scoreboard;
    logic [NPIX-1:0]  tmpl [NCLS];
    logic [CONFW-1:0] conf [NCLS][NPIX];
    verdict_t         verdicts_due [$];
    int n_errors, n_checked, n_classify, n_train, n_rejected, n_held_max, n_flipped;

    function new();
      for (int n = 0; n < NCLS; n++) begin
        tmpl[n] = '0;
        for (int i = 0; i < NPIX; i++) conf[n][i] = '0;
      end
    endfunction

    // Pixels beyond the image field read as empty.
    function logic pixel(logic [IMAGE_W-1:0] img, int i);
      return (i < IMAGE_W) ? img[i] : 1'b0;
    endfunction

    function void raise_conf(int n, int i);
      if (conf[n][i] == {CONFW{1'b1}}) n_held_max++;
      else conf[n][i] = conf[n][i] + 1'b1;
    endfunction

    // Fair mode lifts every other class first; then the labelled class moves
    // toward the image, flipping a template bit when its counter runs out.
    function void apply_training(logic [IMAGE_W-1:0] img, int lbl, logic fair);
      if (fair) begin
        for (int n = 0; n < NCLS; n++)
          if (n != lbl)
            for (int i = 0; i < NPIX; i++) raise_conf(n, i);
      end
      for (int i = 0; i < NPIX; i++) begin
        if (pixel(img, i) == tmpl[lbl][i]) begin
          raise_conf(lbl, i);
        end else if (conf[lbl][i] == '0) begin
          tmpl[lbl][i] = ~tmpl[lbl][i];
          conf[lbl][i] = CONFW'(1);
          n_flipped++;
        end else begin
          conf[lbl][i] = conf[lbl][i] - 1'b1;
        end
      end
    endfunction

    // Signed match score per class; a later class wins only when strictly higher.
    function verdict_t score_image(logic [IMAGE_W-1:0] img);
      verdict_t v;
      longint   acc;
      longint   best;
      v.cls     = '0;
      v.invalid = 1'b0;
      best      = 0;
      for (int n = 0; n < NCLS; n++) begin
        acc = 0;
        for (int i = 0; i < NPIX; i++) begin
          if (pixel(img, i) == tmpl[n][i]) acc += longint'(conf[n][i]);
          else acc -= longint'(conf[n][i]);
        end
        if (n == 0 || acc > best) begin
          best  = acc;
          v.cls = CLASS_W'(n);
        end
      end
      v.score = best[SCORE_W-1:0];
      return v;
    endfunction

    // Called for every accepted input word.
    function void note_word(logic op, logic [IMAGE_W-1:0] img, logic [LABEL_W-1:0] lbl,
                            logic fair);
      verdict_t v;
      v.cls     = '0;
      v.score   = '0;
      v.invalid = 1'b0;
      if (op == OP_CLASSIFY) begin
        v = score_image(img);
        n_classify++;
      end else if (lbl >= NCLS) begin
        v.invalid = 1'b1;
        n_rejected++;
      end else begin
        apply_training(img, int'(lbl), fair);
        n_train++;
      end
      verdicts_due.push_back(v);
    endfunction

    // Every mismatch prints one line and is counted.
    task report_mismatch(string what, longint got, longint want);
      n_errors++;
      $display("mismatch: %s got %0d expected %0d (result %0d)", what, got, want,
               n_checked);
    endtask

    // Called for every accepted result word.
    task check_word(logic [CLASS_W-1:0] cls, logic signed [SCORE_W-1:0] score,
                    logic invalid);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        report_mismatch("result word with nothing pending:", longint'(cls), 0);
        return;
      end
      want = verdicts_due.pop_front();
      n_checked++;
      if (cls !== want.cls) report_mismatch("predicted_class", cls, want.cls);
      if (score !== want.score) report_mismatch("best_score", score, want.score);
      if (invalid !== want.invalid) report_mismatch("label_invalid", invalid, want.invalid);
    endtask
  endclass

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic                      operation = OP_CLASSIFY;
  logic [IMAGE_W-1:0]        image     = '0;
  logic [LABEL_W-1:0]        label     = '0;
  logic                      fair_mode = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [CLASS_W-1:0]        predicted_class;
  logic signed [SCORE_W-1:0] best_score;
  logic                      label_invalid;

  template_scoreboard sb;
  logic [IMAGE_W-1:0] protos [NCLS];
  int  send_idle_pct   = 20;
  int  recv_idle_pct   = 53;
  bit  hold_req        = 1'b0;
  int  hold_left       = 0;
  int  n_holds         = 0;
  int  quiet_cycles    = 0;
  int  in_stall_cycles = 0;

  digit_template_classifier_top u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .operation_i       (operation),
    .image_i           (image),
    .label_i           (label),
    .fair_mode_i       (fair_mode),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .predicted_class_o (predicted_class),
    .best_score_o      (best_score),
    .label_invalid_o   (label_invalid)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Result side: random back-pressure, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watch both channels: note input words, check result words, and stop the run
  // when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_word(operation, image, label, fair_mode);
      if (in_valid && !in_ready) in_stall_cycles++;
      if (out_valid && out_ready) sb.check_word(predicted_class, best_score, label_invalid);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word accepted for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [IMAGE_W-1:0] rand_image();
    return IMAGE_W'($urandom);
  endfunction

  // Offer one word after an optional random gap and return at the edge that
  // takes it.
  task automatic send_word(logic op, logic [IMAGE_W-1:0] img, logic [LABEL_W-1:0] lbl,
                           logic fair);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    image     <= img;
    label     <= lbl;
    fair_mode <= fair;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering until every pending result word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.verdicts_due.size() != 0);
  endtask

  task automatic request_hold();
    hold_req = 1'b1;
    n_holds++;
  endtask

  // Empty state, invalid labels, template flips on underflow, ties and negative
  // scores, in a fixed order.
  task automatic drive_directed();
    send_word(OP_CLASSIFY, '0, '0, 1'b0);
    send_word(OP_CLASSIFY, '1, '1, 1'b1);
    send_word(OP_TRAIN, rand_image(), LABEL_W'(10), 1'b1);
    send_word(OP_TRAIN, '1, '1, 1'b0);
    send_word(OP_TRAIN, '1, LABEL_W'(9), 1'b0);
    send_word(OP_TRAIN, '0, '0, 1'b1);
    send_word(OP_CLASSIFY, '1, '0, 1'b0);
    send_word(OP_CLASSIFY, '0, '0, 1'b0);
    send_word(OP_CLASSIFY, IMAGE_W'(32'h0AAAAAA), '1, 1'b1);
    send_word(OP_TRAIN, IMAGE_W'(32'h1555555), LABEL_W'(3), 1'b0);
    send_word(OP_TRAIN, IMAGE_W'(32'h1555555), LABEL_W'(3), 1'b1);
    send_word(OP_TRAIN, IMAGE_W'(32'h0AAAAAA), LABEL_W'(3), 1'b0);
    send_word(OP_TRAIN, IMAGE_W'(32'h0AAAAAA), LABEL_W'(3), 1'b0);
    send_word(OP_TRAIN, IMAGE_W'(32'h0AAAAAA), LABEL_W'(3), 1'b0);
    send_word(OP_CLASSIFY, IMAGE_W'(32'h0AAAAAA), '0, 1'b0);
    send_word(OP_CLASSIFY, IMAGE_W'(32'h1555555), '0, 1'b0);
    send_word(OP_TRAIN, IMAGE_W'(32'h0000001), LABEL_W'(7), 1'b1);
    send_word(OP_TRAIN, '0, LABEL_W'(12), 1'b1);
    send_word(OP_CLASSIFY, IMAGE_W'(32'h1000000), '0, 1'b0);
    send_word(OP_TRAIN, '1, LABEL_W'(1), 1'b1);
    send_word(OP_CLASSIFY, '1, '0, 1'b0);
  endtask

  // Mostly noisy copies of per-class prototypes, trained under their own label
  // or classified, with random images and rejected labels mixed in.
  // Rejected train words do not count toward the total.
  task automatic run_random(int count);
    int                 done;
    int                 pick;
    int                 k;
    logic [IMAGE_W-1:0] noise;
    logic [LABEL_W-1:0] lbl;
    logic               fair;
    done = 0;
    while (done < count) begin
      pick  = $urandom_range(99);
      k     = $urandom_range(NCLS - 1);
      noise = IMAGE_W'($urandom & $urandom & $urandom);
      lbl   = LABEL_W'($urandom_range(15));
      fair  = 1'($urandom_range(1));
      if (pick < 40) begin
        send_word(OP_TRAIN, protos[k] ^ noise, LABEL_W'(k), fair);
      end else if (pick < 80) begin
        send_word(OP_CLASSIFY, protos[k] ^ noise, lbl, fair);
      end else if (pick < 88) begin
        send_word(OP_CLASSIFY, rand_image(), lbl, fair);
      end else if (pick < 94) begin
        send_word(OP_TRAIN, rand_image(), LABEL_W'(k), fair);
      end else begin
        send_word(OP_TRAIN, rand_image(), LABEL_W'($urandom_range(15, NCLS)), fair);
        continue;
      end
      done++;
    end
  endtask

  // A run of fair training on class 0 that lifts every other class's counters,
  // then classify and train words, most of them built from the current templates.
  task automatic drive_saturation();
    int c;
    for (int k = 0; k < SAT_WORDS; k++) send_word(OP_TRAIN, rand_image(), '0, 1'b1);
    for (int k = 0; k < 48; k++) begin
      c = $urandom_range(NCLS - 1, 1);
      case (k % 4)
        0: send_word(OP_CLASSIFY, sb.tmpl[c], LABEL_W'($urandom_range(15)), 1'b0);
        1: send_word(OP_CLASSIFY, rand_image(), '0, 1'b1);
        2: send_word(OP_TRAIN, sb.tmpl[c], LABEL_W'(c), 1'b0);
        default: send_word(OP_TRAIN, ~sb.tmpl[c], LABEL_W'(c), 1'b1);
      endcase
    end
  endtask

  // Main sequence: reset, directed words, three back-pressure phases, fair training.
  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_directed();
    foreach (protos[k]) protos[k] = rand_image();
    run_random(280);
    request_hold();
    run_random(280);

    send_idle_pct = 53;
    recv_idle_pct = 20;
    run_random(280);
    wait_drained();
    run_random(280);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(280);
    request_hold();
    run_random(280);
    drive_saturation();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d classify, %0d train and %0d rejected train words",
             sb.n_classify, sb.n_train, sb.n_rejected);
    $display("%0d results checked, %0d template flips, %0d raises at the maximum, %0d hold-offs",
             sb.n_checked, sb.n_flipped, sb.n_held_max, n_holds);
    if (sb.n_errors == 0 && sb.verdicts_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
